// File: design/fpa_pkg.sv
// Package for the fit-policy partition allocator.
// Holds command, status and mode codes, controller states and the control structs.
// No dependencies; every other design file imports it.
package fpa_pkg;

	localparam int CMD_W    = 2;
	localparam int SLOT_W   = 4;
	localparam int AMOUNT_W = 32;
	localparam int STATUS_W = 2;
	localparam int LOC_W    = 4;
	localparam int LEFT_W   = 32;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;
	localparam int MODE_W   = 2;
	localparam int PIU_W    = 5;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_PLACED = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOFIT  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic REG_FIT_MODE = 1'b0;
	localparam logic REG_PIU      = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_REPLY
	} fpa_state_t;

	typedef struct packed {
		logic capture;
		logic issue;
		logic reply;
	} fpa_ctrl_t;

	typedef struct packed {
		logic rem_zero;
		logic rem_one;
		logic out_free;
	} fpa_stat_t;

endpackage

// File: design/fit_policy_partition_allocator.sv
// Top level of the fit-policy partition allocator.
// Holds the register port and joins fpa_ctrl and fpa_datapath; depends on fpa_pkg.
//
// Usage: the slave stream carries commands. s_tuser holds the command (load,
// allocate, restore) and s_tdata holds the slot and the amount. Every input
// transaction produces exactly one output transaction on the master stream,
// whose tdata holds the status, the chosen location and the space left.
// fit_mode and partitions_in_use are written over the register port; the user
// must write them only while the block is idle, as the block does not enforce it.
// One command is worked on at a time. Each table memory has a single read port
// and is swept one entry per cycle: allocate reads the partitions searched,
// restore reads all MAX_PARTITIONS entries, and load and unused commands skip
// the sweep. A new command is taken on the cycle after the previous result is
// loaded into the output register.
// Reset clears both tables (per-entry valid bits), the registers and all
// control state; no clearing sweep is needed. When the receiver stalls, the
// result waits in the output register, the next command is still accepted and
// processed, and its reply waits until the output register is free.
module fit_policy_partition_allocator
	import fpa_pkg::*;
#(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS      = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // slot[3:0], amount[35:4], zero pad[39:36]
	input  logic [CMD_W-1:0]    s_tuser,  // command[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // status[1:0], location[5:2], space_left[37:6]
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [MODE_W-1:0]   fit_mode_q;
	logic [PIU_W-1:0]    piu_q;
	logic                reg_sel;
	fpa_ctrl_t           ctrl;
	fpa_stat_t           stat;
	logic [STATUS_W-1:0] out_status;
	logic [LOC_W-1:0]    out_location;
	logic [LEFT_W-1:0]   out_space_left;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_BEST;
			piu_q      <= PIU_W'(1);
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_FIT_MODE: fit_mode_q <= pwdata[MODE_W-1:0];
				REG_PIU:      piu_q      <= pwdata[PIU_W-1:0];
				default:      fit_mode_q <= fit_mode_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_FIT_MODE: prdata = {{(32-MODE_W){1'b0}}, fit_mode_q};
			REG_PIU:      prdata = {{(32-PIU_W){1'b0}}, piu_q};
			default:      prdata = '0;
		endcase
	end

	fpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	fpa_datapath #(
		.MAX_PARTITIONS (MAX_PARTITIONS),
		.SIZE_BITS      (SIZE_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.stat              (stat),
		.in_kind           (s_tuser),
		.in_slot           (s_tdata[SLOT_W-1:0]),
		.in_amount         (s_tdata[SLOT_W+AMOUNT_W-1:SLOT_W]),
		.fit_mode          (fit_mode_q),
		.partitions_in_use (piu_q),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_status        (out_status),
		.out_location      (out_location),
		.out_space_left    (out_space_left)
	);

	assign m_tdata = {2'b00, out_space_left, out_location, out_status};

endmodule

// File: design/fpa_ctrl.sv
// Controller state machine of the partition allocator.
// Sequences capture, table sweep and reply; depends on fpa_pkg.
module fpa_ctrl
	import fpa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_kind,
	output logic             in_ready,
	input  fpa_stat_t        stat,
	output fpa_ctrl_t        ctrl
);

	fpa_state_t state_q;
	fpa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.capture = 1'b1;
					if (in_kind == CMD_ALLOC || in_kind == CMD_RESTORE) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_REPLY;
					end
				end
			end
			ST_SCAN: begin
				ctrl.issue = !stat.rem_zero;
				if (stat.rem_zero || stat.rem_one) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_REPLY;
			end
			ST_REPLY: begin
				if (stat.out_free) begin
					ctrl.reply = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/fpa_datapath.sv
// Datapath of the partition allocator: size and free-space memories, sweep counters,
// best-candidate tracking and the output register. Depends on fpa_pkg.
module fpa_datapath
	import fpa_pkg::*;
#(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS      = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fpa_ctrl_t           ctrl,
	output fpa_stat_t           stat,
	input  logic [CMD_W-1:0]    in_kind,
	input  logic [SLOT_W-1:0]   in_slot,
	input  logic [AMOUNT_W-1:0] in_amount,
	input  logic [MODE_W-1:0]   fit_mode,
	input  logic [PIU_W-1:0]    partitions_in_use,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [LOC_W-1:0]    out_location,
	output logic [LEFT_W-1:0]   out_space_left
);

	localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

	logic [SIZE_BITS-1:0] orig_mem [MAX_PARTITIONS];
	logic [SIZE_BITS-1:0] free_mem [MAX_PARTITIONS];
	logic [MAX_PARTITIONS-1:0] orig_vld_q;
	logic [MAX_PARTITIONS-1:0] free_vld_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     rem_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_q;
	logic [SIZE_BITS-1:0] best_f_q;

	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 fv_s1;
	logic                 ov_s1;
	logic [SIZE_BITS-1:0] rd_free_s1;
	logic [SIZE_BITS-1:0] rd_orig_s1;

	logic                 out_vld_q;
	logic [STATUS_W-1:0]  status_q;
	logic [LOC_W-1:0]     location_q;
	logic [LEFT_W-1:0]    left_q;

	logic [CNT_W-1:0]     search_cnt;
	logic [SIZE_BITS-1:0] cand_f;
	logic                 better;
	logic                 slot_ok;
	logic [IDX_W-1:0]     slot_idx;
	logic [SIZE_BITS-1:0] remain;
	logic                 fw_en;
	logic                 ow_en;
	logic [IDX_W-1:0]     fw_addr;
	logic [SIZE_BITS-1:0] fw_data;

	assign search_cnt = (int'(partitions_in_use) > MAX_PARTITIONS) ?
		CNT_W'(MAX_PARTITIONS) : CNT_W'(partitions_in_use);
	assign slot_ok  = int'(slot_q) < MAX_PARTITIONS;
	assign slot_idx = IDX_W'(slot_q);
	assign remain   = best_f_q - req_q;

	assign cand_f = fv_s1 ? rd_free_s1 : '0;
	always_comb begin
		better = 1'b0;
		if (cand_f >= req_q) begin
			if (!found_q) begin
				better = 1'b1;
			end else begin
				case (fit_mode)
					MODE_FIRST: better = 1'b0;
					MODE_WORST: better = cand_f > best_f_q;
					default:    better = cand_f < best_f_q;
				endcase
			end
		end
	end

	assign stat.rem_zero = rem_q == '0;
	assign stat.rem_one  = rem_q == CNT_W'(1);
	assign stat.out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rem_q   <= '0;
			found_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= ctrl.issue;
			if (ctrl.capture) begin
				idx_q   <= '0;
				rem_q   <= (in_kind == CMD_RESTORE) ? CNT_W'(MAX_PARTITIONS) : search_cnt;
				found_q <= 1'b0;
			end else begin
				if (ctrl.issue) begin
					idx_q <= idx_q + 1'b1;
					rem_q <= rem_q - 1'b1;
				end
				if (vld_s1 && cmd_q == CMD_ALLOC && better) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q  <= in_kind;
			slot_q <= in_slot;
			req_q  <= SIZE_BITS'(in_amount);
		end
		idx_s1     <= idx_q;
		fv_s1      <= free_vld_q[idx_q];
		ov_s1      <= orig_vld_q[idx_q];
		rd_free_s1 <= free_mem[idx_q];
		rd_orig_s1 <= orig_mem[idx_q];
		if (vld_s1 && cmd_q == CMD_ALLOC && better) begin
			best_q   <= idx_s1;
			best_f_q <= cand_f;
		end
	end

	always_comb begin
		fw_en   = 1'b0;
		ow_en   = 1'b0;
		fw_addr = idx_s1;
		fw_data = ov_s1 ? rd_orig_s1 : '0;
		if (vld_s1 && cmd_q == CMD_RESTORE) begin
			fw_en = 1'b1;
		end else if (ctrl.reply && cmd_q == CMD_ALLOC && found_q) begin
			fw_en   = 1'b1;
			fw_addr = best_q;
			fw_data = remain;
		end else if (ctrl.reply && cmd_q == CMD_LOAD && slot_ok) begin
			fw_en   = 1'b1;
			ow_en   = 1'b1;
			fw_addr = slot_idx;
			fw_data = req_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fw_en) begin
			free_mem[fw_addr] <= fw_data;
		end
		if (ow_en) begin
			orig_mem[fw_addr] <= fw_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_vld_q <= '0;
			orig_vld_q <= '0;
		end else begin
			if (fw_en) begin
				free_vld_q[fw_addr] <= 1'b1;
			end
			if (ow_en) begin
				orig_vld_q[fw_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctrl.reply) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.reply) begin
			status_q   <= STAT_DONE;
			location_q <= '0;
			left_q     <= '0;
			if (cmd_q == CMD_ALLOC) begin
				if (found_q) begin
					status_q   <= STAT_PLACED;
					location_q <= LOC_W'(best_q);
					left_q     <= LEFT_W'(remain);
				end else begin
					status_q <= STAT_NOFIT;
				end
			end
		end
	end

	assign out_valid      = out_vld_q;
	assign out_status     = status_q;
	assign out_location   = location_q;
	assign out_space_left = left_q;

endmodule

// File: design/fpa_checker.sv
// Port-level checker for the partition allocator, bound to the top level.
// Depends on fpa_pkg for the status codes.
module fpa_checker
	import fpa_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled output transaction changed or vanished.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A second command was taken while one was in progress.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] == STAT_PLACED || m_tdata[1:0] == STAT_NOFIT ||
			m_tdata[1:0] == STAT_DONE)
		else $error("Output status is not a defined code.");

	a_unplaced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != STAT_PLACED |-> m_tdata[39:2] == '0)
		else $error("Unplaced result carries a location or space.");

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for fit_policy_partition_allocator: directed commands, then random command
// streams under every fit policy, checked against a scoreboard that models the partition table.
// Depends on fpa_pkg and the allocator RTL.
module tb;
	import fpa_pkg::*;

	localparam logic [CMD_W-1:0]  CMD_SPARE  = 2'd3;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int N_PART         = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LOC_W-1:0]    location;
		logic [LEFT_W-1:0]   space_left;
	} alloc_result_t;

	class alloc_scoreboard;
		logic [AMOUNT_W-1:0] orig_size[N_PART];
		logic [AMOUNT_W-1:0] free_sp[N_PART];
		logic [MODE_W-1:0]   fit_mode;
		logic [PIU_W-1:0]    piu;
		alloc_result_t       awaited[$];
		int                  errors;

		function new();
			foreach (orig_size[i]) begin
				orig_size[i] = '0;
				free_sp[i] = '0;
			end
			fit_mode = MODE_BEST;
			piu = 5'd1;
			errors = 0;
		endfunction

		function void set_config(logic idx, logic [31:0] value);
			if (idx == REG_FIT_MODE) begin
				fit_mode = value[MODE_W-1:0];
			end else begin
				piu = value[PIU_W-1:0];
			end
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
				logic [AMOUNT_W-1:0] amount);
			alloc_result_t r;
			int            cnt;
			int            pick;
			bit            found;
			r = '{STAT_DONE, '0, '0};
			case (cmd)
				CMD_LOAD: begin
					orig_size[slot] = amount;
					free_sp[slot] = amount;
				end
				CMD_RESTORE: begin
					foreach (free_sp[i]) free_sp[i] = orig_size[i];
				end
				CMD_ALLOC: begin
					cnt = (piu > N_PART) ? N_PART : int'(piu);
					found = 0;
					pick = 0;
					for (int i = 0; i < cnt; i++) begin
						if (free_sp[i] < amount) continue;
						if (!found) begin
							found = 1;
							pick = i;
							if (fit_mode == MODE_FIRST) break;
						end else if (fit_mode == MODE_WORST) begin
							if (free_sp[i] > free_sp[pick]) pick = i;
						end else if (free_sp[i] - amount < free_sp[pick] - amount) begin
							pick = i;
						end
					end
					if (found) begin
						free_sp[pick] = free_sp[pick] - amount;
						r = '{STAT_PLACED, pick[LOC_W-1:0], free_sp[pick]};
					end else begin
						r.status = STAT_NOFIT;
					end
				end
				default: ;
			endcase
			awaited.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
			errors++;
		endtask

		task check_result(logic [M_DATA_W-1:0] d);
			alloc_result_t e;
			if (awaited.size() == 0) begin
				report("unexpected transaction, data", d[31:0], '0);
				return;
			end
			e = awaited.pop_front();
			if (d[1:0] != e.status) report("status", 32'(d[1:0]), 32'(e.status));
			if (d[5:2] != e.location) report("location", 32'(d[5:2]), 32'(e.location));
			if (d[37:6] != e.space_left) report("space_left", d[37:6], e.space_left);
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	alloc_scoreboard sb = new();
	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;
	int idle_cycles = 0;

	fit_policy_partition_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task send_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
			logic [AMOUNT_W-1:0] amount);
		int gap;
		gap = gaps_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, amount, slot};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, slot, amount);
	endtask

	task apb_write(logic idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_config(idx, value);
	endtask

	task configure(logic [MODE_W-1:0] mode, logic [PIU_W-1:0] count);
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		apb_write(REG_FIT_MODE, {30'b0, mode});
		apb_write(REG_PIU, {27'b0, count});
	endtask

	task random_command(logic [AMOUNT_W-1:0] bound);
		int                  pick;
		int                  shape;
		logic [AMOUNT_W-1:0] amount;
		pick = $urandom_range(0, 99);
		shape = $urandom_range(0, 9);
		if (shape < 6) begin
			amount = $urandom_range(0, bound >> 2);
		end else if (shape < 8) begin
			amount = $urandom_range(0, bound);
		end else begin
			amount = sb.free_sp[$urandom_range(0, N_PART - 1)];
		end
		if (pick < 55) begin
			send_command(CMD_ALLOC, SLOT_W'($urandom_range(0, 15)), amount);
		end else if (pick < 82) begin
			send_command(CMD_LOAD, SLOT_W'($urandom_range(0, 15)), $urandom_range(0, bound));
		end else if (pick < 92) begin
			send_command(CMD_RESTORE, SLOT_W'($urandom_range(0, 15)), $urandom());
		end else begin
			send_command(CMD_SPARE, SLOT_W'($urandom_range(0, 15)), $urandom());
		end
	endtask

	// Receiver: random back-pressure per transaction, plus one long hold-off on request.
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = gaps_on ? $urandom_range(0, 17) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("** fit_policy_partition_allocator: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [MODE_W-1:0]   mode_list[12];
		logic [PIU_W-1:0]    count_list[12];
		logic [AMOUNT_W-1:0] bound_list[5];
		logic [AMOUNT_W-1:0] bound;
		mode_list = '{MODE_BEST, MODE_FIRST, MODE_WORST, MODE_SPARE, MODE_BEST, MODE_FIRST,
			MODE_WORST, MODE_SPARE, MODE_BEST, MODE_FIRST, MODE_WORST, MODE_BEST};
		count_list = '{5'd16, 5'd16, 5'd16, 5'd8, 5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd5,
			5'd16, 5'd12};
		bound_list = '{32'd15, 32'd255, 32'hFFFF_FFFF, 32'd4095, 32'd3};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_LOAD;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: best fit over one partition, empty table.
		send_command(CMD_ALLOC, 4'd0, 32'd0);
		send_command(CMD_ALLOC, 4'd0, 32'd1);
		send_command(CMD_LOAD, 4'd15, 32'hFFFF_FFFF);
		send_command(CMD_LOAD, 4'd0, 32'd100);
		send_command(CMD_SPARE, 4'd5, 32'hA5A5_A5A5);
		send_command(CMD_ALLOC, 4'd0, 32'd100);
		send_command(CMD_RESTORE, 4'd9, 32'h5A5A_5A5A);

		configure(MODE_WORST, 5'd16);
		send_command(CMD_LOAD, 4'd7, 32'd100);
		send_command(CMD_LOAD, 4'd3, 32'd100);
		send_command(CMD_ALLOC, 4'd0, 32'hFFFF_FFFF);
		send_command(CMD_ALLOC, 4'd0, 32'd10);
		send_command(CMD_ALLOC, 4'd0, 32'd95);
		send_command(CMD_RESTORE, 4'd0, 32'd0);
		send_command(CMD_ALLOC, 4'd0, 32'd1);

		configure(MODE_FIRST, 5'd16);
		send_command(CMD_ALLOC, 4'd0, 32'd50);
		send_command(CMD_ALLOC, 4'd0, 32'd0);
		send_command(CMD_ALLOC, 4'd0, 32'd60);

		configure(MODE_BEST, 5'd16);
		send_command(CMD_ALLOC, 4'd0, 32'd40);
		send_command(CMD_ALLOC, 4'd0, 32'd100);

		configure(MODE_BEST, 5'd0);
		send_command(CMD_ALLOC, 4'd0, 32'd0);

		configure(MODE_SPARE, 5'd31);
		send_command(CMD_ALLOC, 4'd0, 32'd5);
		send_command(CMD_ALLOC, 4'd0, 32'h8000_0000);

		for (int p = 0; p < 12; p++) begin
			configure(mode_list[p], count_list[p]);
			gaps_on = (p % 3 != 1);
			bound = bound_list[p % 5];
			for (int s = 0; s < N_PART; s++) begin
				send_command(CMD_LOAD, s[SLOT_W-1:0], $urandom_range(0, bound));
			end
			for (int k = 0; k < 90; k++) begin
				if (p == 5 && k == 20) hold_req = 1'b1;
				random_command(bound);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("** fit_policy_partition_allocator: PASSED **");
		end else begin
			$display("** fit_policy_partition_allocator: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
design/fpa_pkg.sv
design/fpa_ctrl.sv
design/fpa_datapath.sv
design/fit_policy_partition_allocator.sv
design/fpa_checker.sv
test/tb.sv
